[design/sbfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync byte frame checksum parser package
// Shared types, constants and register codes for the frame parser.
// ----------------------------------------------------------------------------
package sbfc_pkg;

  // Number of payload bytes in a frame (legal range 1 to 7).
  localparam int unsigned PAYLOAD_BYTES = 4;

  // Bytes that are kept and packed into the result word.
  localparam int unsigned STORE_DEPTH = 4;
  localparam int unsigned KEPT_BYTES  =
    (PAYLOAD_BYTES < STORE_DEPTH) ? PAYLOAD_BYTES : STORE_DEPTH;

  localparam int unsigned POS_W     = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam byte_t SYNC_RESET = 8'hA6;

  // Register index codes (index taken from paddr bit 2).
  localparam logic REG_SYNC_BYTE = 1'b0;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_e;

  typedef struct packed {
    word_t frame_payload;
    logic  checksum_ok;
    word_t good_frames;
    word_t bad_frames;
  } result_t;

endpackage

[design/sbfc_rx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface sbfc_rx_if;
  logic            valid;
  logic            ready;
  sbfc_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/sbfc_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one frame result per transaction.
// ----------------------------------------------------------------------------
interface sbfc_res_if;
  logic            valid;
  logic            ready;
  sbfc_pkg::word_t frame_payload;
  logic            checksum_ok;
  sbfc_pkg::word_t good_frames;
  sbfc_pkg::word_t bad_frames;

  modport source (output valid, output frame_payload, output checksum_ok,
                  output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input frame_payload, input checksum_ok,
                  input good_frames, input bad_frames, output ready);
endinterface

[design/sbfc_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register port holding the sync byte.
// ----------------------------------------------------------------------------
module sbfc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbfc_pkg::APB_AW-1:0]   paddr,
  input  logic [sbfc_pkg::APB_DW-1:0]   pwdata,
  output logic [sbfc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output sbfc_pkg::byte_t               sync_byte_o
);
  import sbfc_pkg::*;

  byte_t sync_q, sync_d;
  logic  wr_en;
  logic  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    sync_d = sync_q;
    if (wr_en && (reg_idx == REG_SYNC_BYTE)) begin
      sync_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else begin
      sync_q <= sync_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SYNC_BYTE) begin
      prdata = {{(APB_DW-8){1'b0}}, sync_q};
    end
  end

  assign sync_byte_o = sync_q;
endmodule

[design/sbfc_frame_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser core
// Input register, frame phase machine, running sum, payload store and
// frame counters.
// ----------------------------------------------------------------------------
module sbfc_frame_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  sbfc_rx_if.sink            rx,
  input  sbfc_pkg::byte_t    sync_byte_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output sbfc_pkg::result_t  res_o
);
  import sbfc_pkg::*;

  logic   in_v_q;
  byte_t  in_byte_q;
  logic   adv;

  phase_e phase_q, phase_d;
  pos_t   pos_q, pos_d;
  byte_t  sum_q, sum_d;
  word_t  good_q, good_d;
  word_t  bad_q, bad_d;
  byte_t  store_q [KEPT_BYTES];

  logic   last_byte;
  logic   sum_match;

  // The held byte moves on when it yields nothing or the result slot is free.
  assign adv      = in_v_q && (!res_valid_o || res_ready_i);
  assign rx.ready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= (rx.valid && rx.ready) || (in_v_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  assign last_byte = (pos_q == POS_W'(PAYLOAD_BYTES - 1));
  assign sum_match = (in_byte_q == sum_q);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    good_d  = good_q;
    bad_d   = bad_q;
    if (adv) begin
      case (phase_q)
        PH_HUNT: begin
          if (in_byte_q == sync_byte_i) begin
            sum_d   = in_byte_q;
            pos_d   = '0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_d = sum_q + in_byte_q;
          if (last_byte) begin
            pos_d   = '0;
            phase_d = PH_CHECK;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        PH_CHECK: begin
          if (sum_match) begin
            good_d = good_q + WORD_W'(1);
          end else begin
            bad_d = bad_q + WORD_W'(1);
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

  for (genvar i = 0; i < KEPT_BYTES; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (adv && (phase_q == PH_PAYLOAD) && (pos_q == POS_W'(i))) begin
        store_q[i] <= in_byte_q;
      end
    end
  end

  // Outputs: a result is offered only while the checksum byte is held.
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.frame_payload = '0;
    for (int i = 0; i < KEPT_BYTES; i++) begin
      res_o.frame_payload[8*i +: 8] = store_q[i];
    end
    res_o.checksum_ok = sum_match;
    res_o.good_frames = sum_match ? (good_q + WORD_W'(1)) : good_q;
    res_o.bad_frames  = sum_match ? bad_q : (bad_q + WORD_W'(1));
    case (phase_q)
      PH_CHECK: res_valid_o = in_v_q;
      default:  res_valid_o = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  a_one_count_per_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (phase_q == PH_CHECK)) |=>
      ((good_q + bad_q) == ($past(good_q) + $past(bad_q) + WORD_W'(1))))
    else $error("frame counters did not advance by exactly one");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < POS_W'(PAYLOAD_BYTES)))
    else $error("payload position beyond frame length");

  a_pos_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_PAYLOAD) |-> (pos_q == '0))
    else $error("payload position not cleared outside payload phase");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && (phase_q == PH_CHECK)) |=> ($stable(good_q) && $stable(bad_q)))
    else $error("frame counters changed without a checksum byte");
`endif
endmodule

[design/sbfc_result_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Output register that holds one frame result until it is taken.
// ----------------------------------------------------------------------------
module sbfc_result_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  sbfc_pkg::result_t  res_i,
  sbfc_res_if.source         res
);
  import sbfc_pkg::*;

  logic    out_v_q;
  result_t out_q;

  assign res_ready_o = !out_v_q || res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready_o) begin
      out_v_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      out_q <= res_i;
    end
  end

  assign res.valid         = out_v_q;
  assign res.frame_payload = out_q.frame_payload;
  assign res.checksum_ok   = out_q.checksum_ok;
  assign res.good_frames   = out_q.good_frames;
  assign res.bad_frames    = out_q.bad_frames;
endmodule

[design/sync_byte_frame_checksum_parser.sv]
`timescale 1ns / 1ps
// Result path: an accepted checksum byte is held in the core's input register,
// and the frame result is then loaded into the result register and offered.
// Throughput: one received byte per cycle while the result register can take a
// finished frame; a checksum byte waits while it is full and stalled downstream.
// Reset: rst_ni is asynchronous and active low; it returns the parser to
// hunting, clears the sum and both frame counters and loads sync byte 0xA6.
// ----------------------------------------------------------------------------
// Sync byte frame checksum parser
// Hunts for a sync byte, collects a fixed-length payload with an additive
// 8-bit checksum and reports each frame with running good and bad counts.
// ----------------------------------------------------------------------------
module sync_byte_frame_checksum_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sbfc_rx_if.sink                       rx_i,
  sbfc_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbfc_pkg::APB_AW-1:0]   paddr,
  input  logic [sbfc_pkg::APB_DW-1:0]   pwdata,
  output logic [sbfc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import sbfc_pkg::*;

  // The sync byte seeds each frame's checksum. It is compared only while
  // hunting, so a rewrite during a frame takes effect from the next hunt.
  byte_t   sync_byte;

  // Handshake between the parser core and the result register. A result
  // is offered only while the checksum byte sits in the core's input
  // register; every other byte moves through without a result.
  logic    res_valid;
  logic    res_ready;
  result_t result;

  sbfc_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sync_byte_o (sync_byte)
  );

  // The core registers each incoming byte, then in the following cycle
  // updates phase, position, sum, payload store and counters. A byte that
  // closes a frame waits in the input register only while the result
  // register is full and its transaction is stalled downstream.
  sbfc_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .sync_byte_i (sync_byte),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (result)
  );

  // The result register decouples the two sides so that new bytes keep
  // being accepted while a finished frame waits to be taken.
  sbfc_result_reg u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (result),
    .res         (res_o)
  );
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser regression bench
// Drives received bytes into the sync byte frame parser and checks every
// frame report against a cycle-free predictor of the hunt, payload and
// checksum phases. A short opening table is followed by random frames, noise
// and broken frames under several sync byte settings. The bench also applies
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import sbfc_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // The result passes through the core's input register and the result register,
  // so settle() also lets SETTLE_CYCLES pass before the register is touched.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_QUOTA   = 345;
  localparam logic [APB_AW-1:0] SYNC_ADDR = {REG_SYNC_BYTE, 2'b00};

  typedef struct packed {
    byte_t   data;
    logic    typed;
    result_t want;
  } opening_row_t;

  localparam result_t NO_RESULT = '0;

  // Opening table: noise while hunting, an all-zero frame with a good
  // checksum, an all-ones frame with a bad checksum, and a frame whose
  // payload carries the sync value itself, which must be taken as data.
  localparam int unsigned OPENING_ROWS = 20;
  localparam opening_row_t OPENING [OPENING_ROWS] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{SYNC_RESET, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{SYNC_RESET, 1'b1, '{32'h0000_0000, 1'b1, 32'd1, 32'd0}},
    '{SYNC_RESET, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{32'hFFFF_FFFF, 1'b0, 32'd1, 32'd1}},
    '{SYNC_RESET, 1'b0, NO_RESULT},
    '{SYNC_RESET, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'h4C, 1'b0, NO_RESULT}
  };

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  sbfc_rx_if  rx ();
  sbfc_res_if res ();

  sync_byte_frame_checksum_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the parser as the bench believes it to be.
  byte_t   cur_sync;
  phase_e  trk_phase;
  pos_t    trk_pos;
  byte_t   trk_store [STORE_DEPTH];
  byte_t   trk_sum;
  word_t   trk_good;
  word_t   trk_bad;

  // Frame reports still owed by the block, oldest first.
  result_t pending_frames [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_len;
  int unsigned engaged_bytes;
  int unsigned bytes_sent;
  int unsigned frames_seen;
  int unsigned sync_settings;

  always begin
    #HALF_PERIOD clk_i = ~clk_i;
  end

  // Advances the predictor by one accepted byte. The return value says
  // whether the byte did anything, so that bytes discarded while hunting do
  // not count towards the stimulus quota.
  function automatic bit parse_byte(input byte_t b, output bit produced,
                                    output result_t rep);
    bit engaged;
    engaged  = 1'b1;
    produced = 1'b0;
    rep      = '0;
    case (trk_phase)
      PH_HUNT: begin
        engaged = (b == cur_sync);
        if (engaged) begin
          trk_sum   = b;
          trk_pos   = '0;
          trk_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (trk_pos < STORE_DEPTH) trk_store[trk_pos] = b;
        trk_sum = trk_sum + b;
        if (int'(trk_pos) + 1 >= PAYLOAD_BYTES) begin
          trk_pos   = '0;
          trk_phase = PH_CHECK;
        end else begin
          trk_pos = trk_pos + 1'b1;
        end
      end
      PH_CHECK: begin
        rep.checksum_ok = (b == trk_sum);
        if (rep.checksum_ok) trk_good = trk_good + 1;
        else trk_bad = trk_bad + 1;
        // Bytes above a short payload stay zero.
        for (int i = 0; i < KEPT_BYTES; i++) rep.frame_payload[8*i +: 8] = trk_store[i];
        rep.good_frames = trk_good;
        rep.bad_frames  = trk_bad;
        produced        = 1'b1;
        trk_phase       = PH_HUNT;
      end
      default: trk_phase = PH_HUNT;
    endcase
    return engaged;
  endfunction

  function automatic void report_mismatch(input string what, input word_t want,
                                          input word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected 0x%08h, got 0x%08h", what, want, got);
  endfunction

  // Offers one byte and waits for its transaction. Before each burst the
  // sender may leave the channel idle for a random gap.
  task automatic offer_byte(input byte_t b, input bit typed, input result_t want);
    int unsigned gap;
    bit produced;
    result_t rep;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        rx.valid   <= 1'b0;
        rx.rx_byte <= byte_t'($urandom);
      end
    end
    burst_left--;
    @(negedge clk_i);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    bytes_sent++;
    if (parse_byte(b, produced, rep)) engaged_bytes++;
    if (produced) pending_frames.push_back(typed ? want : rep);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    rx.valid <= 1'b0;
  endtask

  // Lowers valid, then waits until every owed report has come back and the
  // pipeline has had time to empty.
  task automatic settle();
    drop_valid();
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(input byte_t value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SYNC_ADDR;
    pwdata  <= {24'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_sync = value;
    sync_settings++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic readback_sync();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SYNC_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== cur_sync)
      report_mismatch("sync byte readback", word_t'(cur_sync), word_t'(prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Payload bytes lean towards the extremes and the current sync value,
  // which the parser must treat as plain data inside a frame.
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return cur_sync;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Random traffic until the quota of bytes that the parser acts on is met.
  // Most of it is well-formed frames, the rest is noise between frames and
  // frames cut short so that the next sync byte lands in the payload.
  task automatic run_traffic(input int unsigned quota, input bit squeeze);
    int unsigned start;
    int unsigned kind;
    int unsigned cut;
    bit squeezed;
    byte_t sum;
    byte_t data;
    start    = engaged_bytes;
    squeezed = 1'b0;
    while (engaged_bytes - start < quota) begin
      if (squeeze && !squeezed && engaged_bytes - start > quota / 3) begin
        // The receiver holds off on its own while frames keep coming, so the
        // block fills up and has to push back on the byte channel.
        hold_len = HOLD_OFF_CYCLES;
        squeezed = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        sum = cur_sync;
        offer_byte(cur_sync, 1'b0, NO_RESULT);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          data = pick_byte();
          sum  = sum + data;
          offer_byte(data, 1'b0, NO_RESULT);
        end
        if ($urandom_range(0, 3) != 0) offer_byte(sum, 1'b0, NO_RESULT);
        else offer_byte(pick_byte(), 1'b0, NO_RESULT);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) offer_byte(byte_t'($urandom), 1'b0, NO_RESULT);
      end else begin
        cut = $urandom_range(0, PAYLOAD_BYTES - 1);
        offer_byte(cur_sync, 1'b0, NO_RESULT);
        repeat (cut) offer_byte(pick_byte(), 1'b0, NO_RESULT);
      end
    end
  endtask

  // Leaves the parser part way into a frame before the sync byte is
  // rewritten, so the frame in progress keeps the seed it started with.
  task automatic open_frame();
    offer_byte(cur_sync, 1'b0, NO_RESULT);
    repeat ($urandom_range(0, PAYLOAD_BYTES - 1)) offer_byte(pick_byte(), 1'b0, NO_RESULT);
  endtask

  // Receiver: random spells of full flow, light stalls and heavy stalls,
  // plus a long hold-off when one is requested.
  initial begin : res_stall
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(4, 60);
        end
        mode_left--;
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= 1'($urandom_range(0, 1));
          default: res.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Each frame report is held against the oldest one owed, field by field.
  always @(posedge clk_i) begin : check_frame
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        report_mismatch("report with no frame owed", '0, res.frame_payload);
      end else begin
        want = pending_frames.pop_front();
        if (res.frame_payload !== want.frame_payload)
          report_mismatch("frame_payload", want.frame_payload, res.frame_payload);
        if (res.checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", word_t'(want.checksum_ok), word_t'(res.checksum_ok));
        if (res.good_frames !== want.good_frames)
          report_mismatch("good_frames", want.good_frames, res.good_frames);
        if (res.bad_frames !== want.bad_frames)
          report_mismatch("bad_frames", want.bad_frames, res.bad_frames);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d reports owed.",
               cycle_count, pending_frames.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    hold_len      = 0;
    engaged_bytes = 0;
    bytes_sent    = 0;
    frames_seen   = 0;
    sync_settings = 1;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    // The predictor starts from the same state that reset gives the block.
    cur_sync  = SYNC_RESET;
    trk_phase = PH_HUNT;
    trk_pos   = '0;
    trk_sum   = '0;
    trk_good  = '0;
    trk_bad   = '0;
    for (int i = 0; i < STORE_DEPTH; i++) trk_store[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // The register must come out of reset holding the default sync byte.
    readback_sync();

    for (int r = 0; r < OPENING_ROWS; r++)
      offer_byte(OPENING[r].data, OPENING[r].typed, OPENING[r].want);

    run_traffic(PHASE_QUOTA, 1'b0);

    // Sweep the sync byte through both extremes and two random values.
    // Every other change is made with a frame left open.
    for (int p = 0; p < 4; p++) begin
      if (p[0]) open_frame();
      settle();
      case (p)
        0:       write_sync(8'h00);
        1:       write_sync(8'hFF);
        default: write_sync(byte_t'($urandom_range(1, 254)));
      endcase
      readback_sync();
      run_traffic(PHASE_QUOTA, p == 1);
    end

    settle();
    $display("Checked %0d frame reports (%0d good, %0d bad) from %0d bytes sent.",
             frames_seen, trk_good, trk_bad, bytes_sent);
    $display("Covered %0d sync byte settings, open frames across rewrites %s%0d-cycle hold-off.",
             sync_settings, "and a ", HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
